### sv/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg: shared types and constants for the cumulative cost curve core
// Result codes, result beat layout and default sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

  localparam int MAX_LEVELS_DEF = 64;
  localparam int VAL_W          = 63;
  localparam int IDX_W          = 6;

  typedef enum logic [1:0] {
    RES_OK       = 2'd0,
    RES_NO_DEPTH = 2'd1,
    RES_OVERFLOW = 2'd2,
    RES_SIDE     = 2'd3
  } build_res_t;

  localparam logic KIND_LEVEL = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] size;
    logic [VAL_W-1:0] qty;
    logic [VAL_W-1:0] cost;
    logic [IDX_W-1:0] idx;
    build_res_t       res;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

### sv/cumulative_cost_curve_core.sv
// ----------------------------------------------------------------------------
// cumulative_cost_curve_core: running quantity and cost over ask levels
// Four-stage pipeline with a split multiplier and a four-beat output queue.
// ----------------------------------------------------------------------------
// One ask level is taken per clock. A level goes through an input register,
// two multiplier stages (price times size as four partial products of the
// 32-bit and 31-bit operand halves, then their sum and the overflow check)
// and the accumulate stage, so its results reach the output queue after the
// input, partial-product and full-product registers. The running totals
// close within the accumulate stage, so back-to-back levels of the same book
// need no gap. A level that is kept and also ends the book yields two output
// beats. The input stalls whenever the output queue has fewer than two free
// entries; with the output never stalled, the sustained rate is one level
// per cycle, less only for books whose last level is kept.
`default_nettype none

module cumulative_cost_curve_core
  import ccc_pkg::*;
#(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wr_en,
  input  wire logic                    cfg_wr_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [63:0]      level_price,
  input  wire logic signed [63:0]      level_size,
  input  wire logic                    last_level,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         result_kind,
  output logic [VAL_W-1:0]             out_price,
  output logic [VAL_W-1:0]             out_size,
  output logic [VAL_W-1:0]             running_qty,
  output logic [VAL_W-1:0]             running_cost,
  output logic [IDX_W-1:0]             level_index,
  output logic [1:0]                   build_result,
  output logic                         last_result
);

  localparam int KEPT_W = $clog2(MAX_LEVELS + 1);
  localparam int Q_DEPTH = 4;
  localparam int QP_W = 2;
  localparam int QC_W = 3;

  logic curve_side;

  // stage A: input register
  logic               a_valid;
  logic signed [63:0] a_price;
  logic signed [63:0] a_size;
  logic               a_last;

  // stage B: partial products
  logic             b_valid;
  logic             b_last;
  logic             b_pos;
  logic [VAL_W-1:0] b_price;
  logic [VAL_W-1:0] b_size;
  logic [63:0]      b_pp_ll;
  logic [62:0]      b_pp_lh;
  logic [62:0]      b_pp_hl;
  logic [61:0]      b_pp_hh;

  // stage C: full product
  logic             c_valid;
  logic             c_last;
  logic             c_pos;
  logic [VAL_W-1:0] c_price;
  logic [VAL_W-1:0] c_size;
  logic [VAL_W-1:0] c_cost;
  logic             c_mul_ovf;

  // build state
  logic [VAL_W-1:0]  total_qty;
  logic [VAL_W-1:0]  total_cost;
  logic [KEPT_W-1:0] levels_kept;
  build_res_t        failure_code;

  // output queue
  result_t         queue [Q_DEPTH];
  logic [QP_W-1:0] head;
  logic [QP_W-1:0] tail;
  logic [QC_W-1:0] count;

  logic advance;
  logic pop;
  logic a_pos;

  logic [63:0]  mid;
  logic [125:0] prod;

  assign advance  = (count <= QC_W'(Q_DEPTH - 2));
  assign in_stall = !advance;
  assign pop      = out_valid && !out_stall;

  assign a_pos = !a_price[63] && (|a_price[62:0]) && !a_size[63] && (|a_size[62:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_side <= 1'b0;
    end else if (cfg_wr_en) begin
      curve_side <= cfg_wr_data;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      a_price <= level_price;
      a_size  <= level_size;
      a_last  <= last_level;

      b_last  <= a_last;
      b_pos   <= a_pos;
      b_price <= a_price[62:0];
      b_size  <= a_size[62:0];
      b_pp_ll <= 64'(a_price[31:0]) * 64'(a_size[31:0]);
      b_pp_lh <= 63'(a_price[31:0]) * 63'(a_size[62:32]);
      b_pp_hl <= 63'(a_price[62:32]) * 63'(a_size[31:0]);
      b_pp_hh <= 62'(a_price[62:32]) * 62'(a_size[62:32]);

      c_last    <= b_last;
      c_pos     <= b_pos;
      c_price   <= b_price;
      c_size    <= b_size;
      c_cost    <= prod[62:0];
      c_mul_ovf <= |prod[125:63];
    end
  end

  always_comb begin
    mid  = 64'(b_pp_lh) + 64'(b_pp_hl);
    prod = 126'(b_pp_ll) + (126'(mid) << 32) + (126'(b_pp_hh) << 64);
  end

  // accumulate stage
  build_res_t        fail_eff;
  build_res_t        fail_upd;
  logic              can_keep;
  logic              keep;
  logic              ovf;
  logic [63:0]       qsum;
  logic [63:0]       csum;
  logic [VAL_W-1:0]  qty_upd;
  logic [VAL_W-1:0]  cost_upd;
  logic [KEPT_W-1:0] kept_upd;
  logic [KEPT_W+IDX_W-1:0] kept_ext;
  result_t           lvl_beat;
  result_t           fin_beat;
  logic              push_lvl;
  logic              push_fin;

  always_comb begin
    fail_eff = (failure_code == RES_OK && curve_side) ? RES_SIDE : failure_code;
    can_keep = (fail_eff == RES_OK) && (levels_kept < KEPT_W'(MAX_LEVELS)) && c_pos;
    qsum     = {1'b0, total_qty} + {1'b0, c_size};
    csum     = {1'b0, total_cost} + {1'b0, c_cost};
    ovf      = c_mul_ovf || qsum[63] || csum[63];
    keep     = can_keep && !ovf;
    fail_upd = (can_keep && ovf) ? RES_OVERFLOW : fail_eff;
    qty_upd  = keep ? qsum[62:0] : total_qty;
    cost_upd = keep ? csum[62:0] : total_cost;
    kept_upd = keep ? levels_kept + KEPT_W'(1) : levels_kept;
    kept_ext = {{IDX_W{1'b0}}, levels_kept};

    lvl_beat.kind  = KIND_LEVEL;
    lvl_beat.price = c_price;
    lvl_beat.size  = c_size;
    lvl_beat.qty   = qsum[62:0];
    lvl_beat.cost  = csum[62:0];
    lvl_beat.idx   = kept_ext[IDX_W-1:0];
    lvl_beat.res   = RES_OK;
    lvl_beat.last  = 1'b0;

    fin_beat.kind  = KIND_FINAL;
    fin_beat.price = '0;
    fin_beat.size  = '0;
    fin_beat.idx   = '0;
    fin_beat.last  = 1'b1;
    if (fail_upd != RES_OK) begin
      fin_beat.res  = fail_upd;
      fin_beat.qty  = '0;
      fin_beat.cost = '0;
    end else begin
      fin_beat.res  = (kept_upd == '0 || qty_upd == '0) ? RES_NO_DEPTH : RES_OK;
      fin_beat.qty  = qty_upd;
      fin_beat.cost = cost_upd;
    end

    push_lvl = c_valid && advance && keep;
    push_fin = c_valid && advance && c_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_qty    <= '0;
      total_cost   <= '0;
      levels_kept  <= '0;
      failure_code <= RES_OK;
    end else if (c_valid && advance) begin
      if (c_last) begin
        // close the book and start clean
        total_qty    <= '0;
        total_cost   <= '0;
        levels_kept  <= '0;
        failure_code <= RES_OK;
      end else begin
        total_qty    <= qty_upd;
        total_cost   <= cost_upd;
        levels_kept  <= kept_upd;
        failure_code <= fail_upd;
      end
    end
  end

  // queue storage: level beat first, final beat behind it
  always_ff @(posedge clk) begin
    if (push_lvl) begin
      queue[tail] <= lvl_beat;
    end
    if (push_fin) begin
      queue[tail + QP_W'(push_lvl)] <= fin_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + QP_W'(pop);
      tail  <= tail + QP_W'(push_lvl) + QP_W'(push_fin);
      count <= count + QC_W'(push_lvl) + QC_W'(push_fin) - QC_W'(pop);
    end
  end

  assign out_valid    = (count != '0);
  assign result_kind  = queue[head].kind;
  assign out_price    = queue[head].price;
  assign out_size     = queue[head].size;
  assign running_qty  = queue[head].qty;
  assign running_cost = queue[head].cost;
  assign level_index  = queue[head].idx;
  assign build_result = queue[head].res;
  assign last_result  = queue[head].last;

endmodule

`default_nettype wire

### sv/ccc_checker.sv
// ----------------------------------------------------------------------------
// ccc_checker: port-level checks for the cumulative cost curve core
// Watches the output channel and the result beat contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_checker
  import ccc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               result_kind,
  input wire logic [VAL_W-1:0]   out_price,
  input wire logic [VAL_W-1:0]   out_size,
  input wire logic [VAL_W-1:0]   running_qty,
  input wire logic [VAL_W-1:0]   running_cost,
  input wire logic [IDX_W-1:0]   level_index,
  input wire logic [1:0]         build_result,
  input wire logic               last_result
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) &&
      $stable(running_qty) && $stable(running_cost) && $stable(build_result))
    else $error("stalled output beat changed");

  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_result == result_kind))
    else $error("last_result disagrees with result_kind");

  a_level_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_LEVEL |->
      build_result == RES_OK && out_price != '0 && out_size != '0 &&
      running_qty >= out_size && running_cost != '0)
    else $error("malformed level beat");

  a_fail_totals: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_FINAL &&
      (build_result == RES_OVERFLOW || build_result == RES_SIDE) |->
      running_qty == '0 && running_cost == '0 && level_index == '0)
    else $error("failed build reports totals");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind cumulative_cost_curve_core ccc_checker u_ccc_checker (.*);

`default_nettype wire

### tb/tb_cumulative_cost_curve_core.sv
// ----------------------------------------------------------------------------
// tb_cumulative_cost_curve_core: self-checking bench for the cost curve core
// Streams ask levels of many books, keeps its own running totals, level
// counts and failure codes to predict each curve beat and final status, and
// compares every output beat field by field. Both sides idle at random and
// the output is held off for a long stretch once to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_cumulative_cost_curve_core;
  import ccc_pkg::*;

  localparam int CURVE_DEPTH = MAX_LEVELS_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [63:0] price;
    logic signed [63:0] size;
    logic               is_last;
  } ask_level_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [63:0] level_price = '0;
  logic signed [63:0] level_size = '0;
  logic last_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic result_kind;
  logic [VAL_W-1:0] out_price;
  logic [VAL_W-1:0] out_size;
  logic [VAL_W-1:0] running_qty;
  logic [VAL_W-1:0] running_cost;
  logic [IDX_W-1:0] level_index;
  logic [1:0] build_result;
  logic last_result;

  // predictor state
  logic [63:0] acc_qty = '0;
  logic [63:0] acc_cost = '0;
  int unsigned kept_cnt = 0;
  build_res_t fail_code = RES_OK;
  logic side_sell = 1'b0;

  ask_level_t ask_q[$];
  result_t curve_q[$];
  ask_level_t drv_lvl;
  result_t want;
  logic in_taken = 1'b0;
  int send_gap_pct = 18;
  int recv_stall_pct = 51;
  logic hold_off = 1'b0;
  int err_cnt = 0;

  cumulative_cost_curve_core #(
    .MAX_LEVELS(CURVE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .level_price(level_price),
    .level_size(level_size),
    .last_level(last_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .out_price(out_price),
    .out_size(out_size),
    .running_qty(running_qty),
    .running_cost(running_cost),
    .level_index(level_index),
    .build_result(build_result),
    .last_result(last_result)
  );

  always #2 clk = ~clk;

  task automatic report_error(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] exp_v);
    if (got !== exp_v) begin
      report_error($sformatf("%s got %0h expected %0h", name, got, exp_v));
    end
  endtask

  // One accepted ask level: update the totals and queue the beats it yields.
  task automatic advance_curve(input logic signed [63:0] price, input logic signed [63:0] size,
                               input logic is_last);
    logic [127:0] prod;
    logic [64:0] qsum;
    logic [64:0] csum;
    logic ovf;
    result_t beat;
    if (fail_code == RES_OK && side_sell) begin
      fail_code = RES_SIDE;
    end
    if (fail_code == RES_OK && kept_cnt < CURVE_DEPTH && price > 0 && size > 0) begin
      prod = {64'd0, price} * {64'd0, size};
      qsum = {1'b0, acc_qty} + {1'b0, size};
      csum = {1'b0, acc_cost} + {1'b0, prod[63:0]};
      ovf = 1'b0;
      if (prod > {64'd0, I64_MAX}) begin
        ovf = 1'b1;
      end else if (qsum > {1'b0, I64_MAX} || csum > {1'b0, I64_MAX}) begin
        ovf = 1'b1;
      end
      if (ovf) begin
        fail_code = RES_OVERFLOW;
      end else begin
        acc_qty = qsum[63:0];
        acc_cost = csum[63:0];
        beat = '0;
        beat.kind = KIND_LEVEL;
        beat.price = price[VAL_W-1:0];
        beat.size = size[VAL_W-1:0];
        beat.qty = acc_qty[VAL_W-1:0];
        beat.cost = acc_cost[VAL_W-1:0];
        beat.idx = kept_cnt[IDX_W-1:0];
        beat.res = RES_OK;
        beat.last = 1'b0;
        curve_q.push_back(beat);
        kept_cnt++;
      end
    end
    if (is_last) begin
      beat = '0;
      beat.kind = KIND_FINAL;
      beat.last = 1'b1;
      if (fail_code != RES_OK) begin
        beat.res = fail_code;
      end else begin
        beat.res = (kept_cnt == 0 || acc_qty == 0) ? RES_NO_DEPTH : RES_OK;
        beat.qty = acc_qty[VAL_W-1:0];
        beat.cost = acc_cost[VAL_W-1:0];
      end
      curve_q.push_back(beat);
      acc_qty = '0;
      acc_cost = '0;
      kept_cnt = 0;
      fail_code = RES_OK;
    end
  endtask

  // Check the output beat first, then take the input beat.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (curve_q.size() == 0) begin
        report_error("output beat with nothing expected");
      end else begin
        want = curve_q.pop_front();
        cmp_field("result_kind", 64'(result_kind), 64'(want.kind));
        cmp_field("out_price", 64'(out_price), 64'(want.price));
        cmp_field("out_size", 64'(out_size), 64'(want.size));
        cmp_field("running_qty", 64'(running_qty), 64'(want.qty));
        cmp_field("running_cost", 64'(running_cost), 64'(want.cost));
        cmp_field("level_index", 64'(level_index), 64'(want.idx));
        cmp_field("build_result", 64'(build_result), 64'(want.res));
        cmp_field("last_result", 64'(last_result), 64'(want.last));
      end
    end
    if (!rst && in_valid && !in_stall) begin
      advance_curve(level_price, level_size, last_level);
      in_taken = 1'b1;
    end
  end

  // Input driver: hold a stalled beat, otherwise offer the next level or idle.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (!rst && ask_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        drv_lvl = ask_q.pop_front();
        in_valid <= 1'b1;
        level_price <= drv_lvl.price;
        level_size <= drv_lvl.size;
        last_level <= drv_lvl.is_last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_level(input logic signed [63:0] price, input logic signed [63:0] size,
                            input logic is_last);
    ask_level_t lvl;
    lvl.price = price;
    lvl.size = size;
    lvl.is_last = is_last;
    ask_q.push_back(lvl);
  endtask

  function automatic ask_level_t pick_level(input bit deep);
    ask_level_t lvl;
    int pick;
    pick = $urandom_range(99);
    if (deep) begin
      pick = pick % 75;
    end
    lvl.price = {$urandom, $urandom};
    lvl.size = {$urandom, $urandom};
    lvl.is_last = 1'b0;
    if (pick < 70) begin
      lvl.price = 64'($urandom_range(1 << 20, 1));
      lvl.size = 64'($urandom_range(1 << 16, 1));
    end else if (pick < 80) begin
      // drop this level: one field zero or negative
      case ($urandom_range(3))
        0: lvl.price = '0;
        1: lvl.size = '0;
        2: lvl.price[63] = 1'b1;
        default: lvl.size[63] = 1'b1;
      endcase
    end else if (pick >= 90) begin
      // large positive values near the overflow edge
      lvl.price[63] = 1'b0;
      lvl.size[63] = 1'b0;
      lvl.price = lvl.price >> $urandom_range(40);
      lvl.size = lvl.size >> $urandom_range(62, 20);
    end
    return lvl;
  endfunction

  task automatic queue_books(input int n_items);
    int left;
    int len;
    bit deep;
    ask_level_t lvl;
    left = n_items;
    while (left > 0) begin
      deep = ($urandom_range(99) < 8);
      len = deep ? $urandom_range(80, 66) : $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
        lvl = pick_level(deep);
        lvl.is_last = (k == len - 1);
        ask_q.push_back(lvl);
      end
      left -= len;
    end
  endtask

  task automatic wait_idle();
    while (ask_q.size() != 0 || in_valid || curve_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_side(input logic v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    side_sell = v;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_gap_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_side(1'b0);

    // empty book, then a book with negative and zero-size dropped levels
    push_level(64'sd0, 64'sd5, 1'b1);
    push_level(I64_MIN, I64_MAX, 1'b0);
    push_level(I64_MAX, I64_MIN, 1'b0);
    push_level(64'sd5, 64'sd0, 1'b0);
    push_level(-64'sd1, -64'sd1, 1'b0);
    push_level(64'sd7, 64'sd3, 1'b0);
    push_level(64'sd2, 64'sd4, 1'b1);
    // cost sum overflow
    push_level(I64_MAX, 64'sd1, 1'b0);
    push_level(64'sd1, 64'sd1, 1'b1);
    // quantity overflow, later levels dropped
    push_level(64'sd1, I64_MAX, 1'b0);
    push_level(64'sd2, 64'sd1, 1'b0);
    push_level(64'sd5, 64'sd5, 1'b1);
    // product overflow on the last level
    push_level(64'sh4000_0000_0000_0000, 64'sd2, 1'b1);
    // wide product kept on the last level: two beats
    push_level(64'sh0000_0000_3FFF_FFFF, 64'sh0000_0001_0000_0001, 1'b1);
    // only dropped levels
    push_level(-64'sd5, 64'sd10, 1'b0);
    push_level(64'sd10, -64'sd5, 1'b1);
    // leave a book open across the switch to sell
    push_level(64'sd3, 64'sd3, 1'b0);
    push_level(64'sd4, 64'sd4, 1'b0);
    wait_idle();

    write_side(1'b1);
    push_level(64'sd9, 64'sd9, 1'b1);
    push_level(64'sd6, 64'sd6, 1'b0);
    push_level(64'sd7, 64'sd7, 1'b1);
    wait_idle();

    write_side(1'b0);
    queue_books(330);
    wait_idle();

    write_side(1'b1);
    queue_books(40);
    wait_idle();

    write_side(1'b0);
    set_idling(51, 18);
    queue_books(290);
    wait_idle();

    // no idling; block the output long enough to back up the input
    set_idling(0, 0);
    queue_books(290);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
    wait_idle();

    if (curve_q.size() != 0) begin
      report_error($sformatf("%0d expected beats never arrived", curve_q.size()));
    end
    if (err_cnt == 0) begin
      $display("** cumulative_cost_curve_core: PASSED **");
    end else begin
      $display("** cumulative_cost_curve_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("timeout: %0d levels pending, %0d beats expected", ask_q.size(), curve_q.size());
    $display("** cumulative_cost_curve_core: FAILED **");
    $finish;
  end

endmodule
